### rtl/sqlb_pkg.sv
// ----------------------------------------------------------------------------
// sqlb_pkg
// Shared types and constants of the signed quadruple table builder.
// ----------------------------------------------------------------------------
package sqlb_pkg;

  // Activation store: one full group of at most 128 samples.
  localparam int STORE_DEPTH = 128;
  localparam int ADDR_W      = 7;

  // Table quantisation: entries scale to +/-127 over the group basis.
  localparam int LUT_QMAX    = 127;
  localparam int QBITS       = 7;   // quotient bits, magnitude never exceeds 127
  localparam int ENTRY_W     = 8;
  localparam int HALF_ENTRIES = 8;

  typedef logic signed [ENTRY_W-1:0] entry_t;

  // Top-level sequencer.
  typedef enum logic [2:0] {
    S_FILL,
    S_LOAD,
    S_START,
    S_WAIT,
    S_OUT0,
    S_OUT1
  } seq_state_t;

  // Quantiser sequencer.
  typedef enum logic [1:0] {
    Q_IDLE,
    Q_DIV,
    Q_ROUND
  } quant_state_t;

endpackage

### rtl/signed_quad_lut_builder_unit.sv
// ----------------------------------------------------------------------------
// signed_quad_lut_builder_unit
// Builds quantised 16-entry signed lookup tables for each activation quadruple.
// ----------------------------------------------------------------------------
// Samples are taken one request per cycle while a group fills (4*GROUP_QUADS
// samples). The request that completes the group starts table generation and
// in_stall stays high until the last result has been loaded into the output
// register. For each quadruple its four samples are read from the activation
// RAM, then entries 0 to 7 each pass through the shared quantiser (start,
// seven restoring-division steps, rounding, capture), then the two results
// are loaded, each waiting out any output stall; entries 8 to 15 are the
// negated mirror of 0 to 7. The result register lets the next group start
// filling while the final result still waits to be taken.
module signed_quad_lut_builder_unit #(
  parameter int GROUP_QUADS = 32,
  parameter int ACT_WIDTH   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // sample request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_activation,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_quad_index,
  output logic               out_half_select,
  output logic [63:0]        out_packed_entries,
  output logic [17:0]        out_max_abs_sum,
  output logic signed [23:0] out_group_bias,
  output logic               out_last
);

  import sqlb_pkg::*;

  localparam int GROUP_SIZE = 4 * GROUP_QUADS;
  localparam int QW = (GROUP_QUADS > 1) ? $clog2(GROUP_QUADS) : 1;
  localparam int MW = ACT_WIDTH + 2;   // quadruple |sum| and group maximum
  localparam int SW = ACT_WIDTH + 7;   // group sum, signed
  localparam int VW = ACT_WIDTH + 3;   // table value, signed

  seq_state_t state_r, state_nxt;

  // Group accumulation.
  logic [ADDR_W-1:0]           fill_r, fill_nxt;
  logic [MW-1:0]               qabs_r, qabs_nxt;
  logic [MW-1:0]               max_r, max_nxt;
  logic signed [SW-1:0]        sum_r, sum_nxt;

  // Table generation.
  logic [QW-1:0]               quad_r, quad_nxt;
  logic [2:0]                  ld_cnt_r, ld_cnt_nxt;
  logic [2:0]                  g_r, g_nxt;
  logic signed [ACT_WIDTH-1:0] b_r [4];
  entry_t                      ent_r [HALF_ENTRIES];

  // Output register.
  logic                        out_valid_r;
  logic [4:0]                  out_quad_r;
  logic                        out_half_r;
  logic [63:0]                 out_packed_r;
  logic [17:0]                 out_max_r;
  logic signed [23:0]          out_bias_r;
  logic                        out_last_r;

  // Control decode.
  logic                        in_acc;
  logic                        out_free;
  logic                        load_out;
  logic                        last_quad;
  logic                        group_done;
  logic                        q_start;
  logic                        q_done;
  entry_t                      q_entry;

  // Sample handling.
  logic [ACT_WIDTH+15:0]       act_ext;
  logic signed [ACT_WIDTH-1:0] act;
  logic signed [ACT_WIDTH:0]   act_wide;
  logic [ACT_WIDTH:0]          act_abs;
  logic [ADDR_W-1:0]           rd_addr;
  logic [ACT_WIDTH-1:0]        rd_data;

  // Table value and result packing.
  logic signed [VW-1:0]        bx [4];
  logic signed [VW-1:0]        tab_v;
  logic [63:0]                 pack_lo;
  logic [63:0]                 pack_hi;
  logic signed [SW+24:0]       bias_wide;
  logic [MW+17:0]              max_wide;

  // Take the low ACT_WIDTH bits of the request and sign-extend them.
  assign act_ext  = {{ACT_WIDTH{1'b0}}, in_activation};
  assign act      = signed'(act_ext[ACT_WIDTH-1:0]);
  assign act_wide = (ACT_WIDTH+1)'(act);
  assign act_abs  = act_wide[ACT_WIDTH] ? (ACT_WIDTH+1)'(-act_wide)
                                        : (ACT_WIDTH+1)'(act_wide);

  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign last_quad  = (quad_r == QW'(GROUP_QUADS - 1));
  assign group_done = (state_r == S_OUT1) && out_free && last_quad;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FILL:  if (in_acc && (fill_r == ADDR_W'(GROUP_SIZE - 1))) state_nxt = S_LOAD;
      S_LOAD:  if (ld_cnt_r == 3'd4) state_nxt = S_START;
      S_START: state_nxt = S_WAIT;
      S_WAIT: begin
        if (q_done) begin
          state_nxt = (g_r == 3'(HALF_ENTRIES - 1)) ? S_OUT0 : S_START;
        end
      end
      S_OUT0:  if (out_free) state_nxt = S_OUT1;
      S_OUT1: begin
        if (out_free) begin
          state_nxt = last_quad ? S_FILL : S_LOAD;
        end
      end
      default: state_nxt = S_FILL;
    endcase
  end

  // Output decode: hold requests off outside the fill phase.
  always_comb begin
    in_stall = 1'b1;
    q_start  = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      S_FILL:  in_stall = 1'b0;
      S_LOAD:  ;
      S_START: q_start = 1'b1;
      S_WAIT:  ;
      S_OUT0:  load_out = out_free;
      S_OUT1:  load_out = out_free;
      default: ;
    endcase
  end

  // Accumulate the group; close each quadruple on its fourth sample.
  always_comb begin
    fill_nxt = fill_r;
    qabs_nxt = qabs_r;
    max_nxt  = max_r;
    sum_nxt  = sum_r;
    if (group_done) begin
      fill_nxt = '0;
      qabs_nxt = '0;
      max_nxt  = '0;
      sum_nxt  = '0;
    end else if (in_acc) begin
      fill_nxt = fill_r + ADDR_W'(1);
      sum_nxt  = sum_r + SW'(act);
      qabs_nxt = qabs_r + MW'(act_abs);
      if (fill_r[1:0] == 2'd3) begin
        if (qabs_nxt > max_r) begin
          max_nxt = qabs_nxt;
        end
        qabs_nxt = '0;
      end
    end
  end

  // Sequencer counters.
  always_comb begin
    ld_cnt_nxt = (state_r == S_LOAD) ? ld_cnt_r + 3'd1 : 3'd0;
    g_nxt      = ((state_r == S_WAIT) && q_done) ? g_r + 3'd1 : g_r;
    quad_nxt   = quad_r;
    if ((state_r == S_OUT1) && out_free) begin
      quad_nxt = last_quad ? '0 : quad_r + QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      fill_r      <= '0;
      qabs_r      <= '0;
      max_r       <= '0;
      sum_r       <= '0;
      quad_r      <= '0;
      ld_cnt_r    <= '0;
      g_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      qabs_r   <= qabs_nxt;
      max_r    <= max_nxt;
      sum_r    <= sum_nxt;
      quad_r   <= quad_nxt;
      ld_cnt_r <= ld_cnt_nxt;
      g_r      <= g_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Activation store: written while filling, read one sample a cycle.
  assign rd_addr = ADDR_W'({quad_r, ld_cnt_r[1:0]});

  sqlb_ram #(
    .WIDTH (ACT_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (fill_r),
    .wdata (act),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Shift the quadruple in as read data returns; b_r[0] ends up as b0.
  always_ff @(posedge clk) begin
    if ((state_r == S_LOAD) && (ld_cnt_r != 3'd0)) begin
      b_r[3] <= signed'(rd_data);
      for (int i = 0; i < 3; i++) begin
        b_r[i] <= b_r[i+1];
      end
    end
  end

  // Table value for entry g of the low half: b3 always enters negated.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      bx[j] = VW'(b_r[j]);
    end
    tab_v = (g_r[0] ? bx[0] : -bx[0])
          + (g_r[1] ? bx[1] : -bx[1])
          + (g_r[2] ? bx[2] : -bx[2])
          - bx[3];
  end

  sqlb_quant #(
    .ACT_WIDTH (ACT_WIDTH)
  ) u_quant (
    .clk   (clk),
    .rst_n (rst_n),
    .start (q_start),
    .value (tab_v),
    .scale (max_r),
    .done  (q_done),
    .entry (q_entry)
  );

  // Collect entries 0..7 in order; ent_r[0] ends up as entry 0.
  always_ff @(posedge clk) begin
    if ((state_r == S_WAIT) && q_done) begin
      ent_r[HALF_ENTRIES-1] <= q_entry;
      for (int i = 0; i < HALF_ENTRIES - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
    end
  end

  // High half mirrors the low half: entry 15-g is the negation of entry g.
  always_comb begin
    for (int k = 0; k < HALF_ENTRIES; k++) begin
      pack_lo[ENTRY_W*k +: ENTRY_W] = ent_r[k];
      pack_hi[ENTRY_W*k +: ENTRY_W] = -ent_r[HALF_ENTRIES-1-k];
    end
  end

  assign bias_wide = -((SW+25)'(sum_r));
  assign max_wide  = (MW+18)'(max_r);

  // Result register; payload holds while stalled.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_quad_r   <= 5'(quad_r);
      out_half_r   <= (state_r == S_OUT1);
      out_packed_r <= (state_r == S_OUT1) ? pack_hi : pack_lo;
      out_max_r    <= max_wide[17:0];
      out_bias_r   <= bias_wide[23:0];
      out_last_r   <= (state_r == S_OUT1) && last_quad;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_quad_index     = out_quad_r;
  assign out_half_select    = out_half_r;
  assign out_packed_entries = out_packed_r;
  assign out_max_abs_sum    = out_max_r;
  assign out_group_bias     = out_bias_r;
  assign out_last           = out_last_r;

endmodule

### rtl/sqlb_ram.sv
// ----------------------------------------------------------------------------
// sqlb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sqlb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/sqlb_quant.sv
// ----------------------------------------------------------------------------
// sqlb_quant
// Iterative quantiser: round_half_even(127*v/m) saturated to +/-127, one
// quotient bit per cycle by restoring division, then a rounding step.
// ----------------------------------------------------------------------------
module sqlb_quant #(
  parameter int ACT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [ACT_WIDTH+2:0]   value,
  input  logic        [ACT_WIDTH+1:0]   scale,
  output logic                          done,
  output sqlb_pkg::entry_t              entry
);

  import sqlb_pkg::*;

  localparam int VW = ACT_WIDTH + 3;   // table value, signed
  localparam int MW = ACT_WIDTH + 2;   // scale basis, unsigned
  localparam int NS = VW + 7;          // 127*value, signed
  localparam int NW = ACT_WIDTH + 8;   // |127*value|, unsigned

  quant_state_t state_r, state_nxt;

  logic [MW-1:0]     rem_r, rem_nxt;
  logic [QBITS-1:0]  low_r, low_nxt;
  logic [QBITS-1:0]  q_r, q_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic              done_r, done_nxt;
  entry_t            entry_r, entry_nxt;

  logic signed [NS-1:0] num;
  logic        [NS-1:0] num_abs;
  logic        [NW-1:0] mag;
  logic        [MW:0]   trial;
  logic                 ge;
  logic        [MW:0]   rem2;
  logic                 round_up;
  logic        [ENTRY_W-1:0] qq;
  logic        [ENTRY_W-1:0] qsat;

  assign num     = NS'(value) * NS'(LUT_QMAX);
  assign num_abs = num[NS-1] ? NS'(-num) : NS'(num);
  assign mag     = num_abs[NW-1:0];

  assign trial = {rem_r, low_r[QBITS-1]};
  assign ge    = trial >= {1'b0, scale};

  assign rem2     = {rem_r, 1'b0};
  assign round_up = (rem2 > {1'b0, scale}) || ((rem2 == {1'b0, scale}) && q_r[0]);
  assign qq       = {1'b0, q_r} + ENTRY_W'(round_up);
  assign qsat     = (qq > ENTRY_W'(LUT_QMAX)) ? ENTRY_W'(LUT_QMAX) : qq;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      Q_IDLE:  if (start) state_nxt = Q_DIV;
      Q_DIV:   if (cnt_r == 3'd0) state_nxt = Q_ROUND;
      Q_ROUND: state_nxt = Q_IDLE;
      default: state_nxt = Q_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    entry_nxt = entry_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      Q_IDLE: begin
        if (start) begin
          rem_nxt = {1'b0, mag[NW-1:QBITS]};
          low_nxt = mag[QBITS-1:0];
          q_nxt   = '0;
          cnt_nxt = 3'(QBITS - 1);
          neg_nxt = num[NS-1];
        end
      end
      Q_DIV: begin
        rem_nxt = ge ? MW'(trial - {1'b0, scale}) : trial[MW-1:0];
        low_nxt = {low_r[QBITS-2:0], 1'b0};
        q_nxt   = {q_r[QBITS-2:0], ge};
        cnt_nxt = cnt_r - 3'd1;
      end
      Q_ROUND: begin
        done_nxt = 1'b1;
        if (scale == '0) begin
          entry_nxt = '0;
        end else if (neg_r) begin
          entry_nxt = entry_t'(-qsat);
        end else begin
          entry_nxt = entry_t'(qsat);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Q_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    low_r   <= low_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    entry_r <= entry_nxt;
  end

  assign done  = done_r;
  assign entry = entry_r;

endmodule
